// ===== hdl/qsf_pkg.sv =====
`default_nettype none

package qsf_pkg;

    localparam int PRICE_BITS   = 32;
    localparam int SUM_BITS     = PRICE_BITS + 1;
    localparam int TOTAL_BITS   = SUM_BITS + 1;
    localparam int THRESH_BITS  = 15;
    localparam int PERSIST_BITS = 8;
    localparam int RUN_BITS     = PERSIST_BITS + 1;
    localparam int CFG_BITS     = THRESH_BITS;
    localparam int PROD_BITS    = TOTAL_BITS + THRESH_BITS;

    // 100 percent times two (mids compared as sums) in hundredths of a percent
    localparam logic [THRESH_BITS-1:0] PCT_SCALE = THRESH_BITS'(20000);

    localparam logic [THRESH_BITS-1:0]  THRESH_RESET  = THRESH_BITS'(100);
    localparam logic [PERSIST_BITS-1:0] PERSIST_RESET = PERSIST_BITS'(3);

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_PERSIST   = 1'b1
    } cfg_index_t;

    typedef logic [PRICE_BITS-1:0] price_t;

    typedef struct packed {
        price_t bid;
        price_t ask;
        logic   swapped;
    } quote_t;

endpackage

`default_nettype wire

// ===== hdl/quote_spike_filter.sv =====
`default_nettype none

// Bid/ask spike filter. Each quote is put in bid <= ask order, then its mid is
// compared with the stored reference mid as a percentage change; quotes that
// move at least the threshold are rejected until more than persist_limit of
// them arrive in a row, at which point the new level is taken as reference.
// Throughput is one quote per clock while results are taken; a quote is held
// in the input register while the cross-multiplied compare and the reference
// update run combinationally into the result register. That update loop on
// the reference and run count sets the rate. While a result waits, one more
// quote is taken into the input register and further quotes stall until the
// result transaction completes.
// Configuration writes take effect at once and are meant for an idle block.
module quote_spike_filter
(
    input  wire                          clk,
    input  wire                          rst_n,

    input  wire                          cfg_we,
    input  wire qsf_pkg::cfg_index_t     cfg_index,
    input  wire [qsf_pkg::CFG_BITS-1:0]  cfg_data,

    input  wire                          quote_valid,
    output logic                         quote_ready,
    input  wire [qsf_pkg::PRICE_BITS-1:0] bid_price,
    input  wire [qsf_pkg::PRICE_BITS-1:0] ask_price,

    output logic                         result_valid,
    input  wire                          result_ready,
    output logic                         rejected,
    output logic [qsf_pkg::PRICE_BITS-1:0] fixed_bid,
    output logic [qsf_pkg::PRICE_BITS-1:0] fixed_ask,
    output logic                         swapped,
    output logic [qsf_pkg::PRICE_BITS-1:0] ref_bid,
    output logic [qsf_pkg::PRICE_BITS-1:0] ref_ask,
    output logic [qsf_pkg::RUN_BITS-1:0] run_length
);
    import qsf_pkg::*;

    logic [THRESH_BITS-1:0]  threshold_reg;
    logic [PERSIST_BITS-1:0] persist_reg;

    logic    stage_valid_reg;
    quote_t  stage_reg;
    quote_t  stage_next;

    logic    ref_valid_reg;
    price_t  ref_bid_reg, ref_bid_next;
    price_t  ref_ask_reg, ref_ask_next;
    logic [RUN_BITS-1:0] run_reg, run_next;

    logic    out_valid_reg;
    logic    rejected_reg, rejected_next;
    quote_t  out_quote_reg;

    logic    advance;
    logic    load_result;

    price_t  base_bid, base_ask;
    logic [SUM_BITS-1:0]   ref_sum, cur_sum, diff;
    logic [TOTAL_BITS-1:0] total;
    logic [PROD_BITS-1:0]  lhs, rhs;
    logic                  spiked;
    logic [RUN_BITS-1:0]   run_inc;
    logic                  take_quote;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            persist_reg   <= PERSIST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_PERSIST:   persist_reg   <= cfg_data[PERSIST_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // handshake: the whole pipe advances when the result slot frees up
    assign advance     = !out_valid_reg || result_ready;
    assign quote_ready = !stage_valid_reg || advance;
    assign load_result = stage_valid_reg && advance;

    // put the quote in order on capture
    always_comb
    begin
        if (bid_price > ask_price)
        begin
            stage_next.bid     = ask_price;
            stage_next.ask     = bid_price;
            stage_next.swapped = 1'b1;
        end
        else
        begin
            stage_next.bid     = bid_price;
            stage_next.ask     = ask_price;
            stage_next.swapped = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (quote_ready)
            stage_valid_reg <= quote_valid;
    end

    always_ff @(posedge clk)
    begin
        if (quote_valid && quote_ready)
            stage_reg <= stage_next;
    end

    // spike test: |R - C| * 20000 >= threshold * (R + C), zero total never spikes
    always_comb
    begin
        base_bid = ref_valid_reg ? ref_bid_reg : stage_reg.bid;
        base_ask = ref_valid_reg ? ref_ask_reg : stage_reg.ask;
        ref_sum  = SUM_BITS'(base_bid) + SUM_BITS'(base_ask);
        cur_sum  = SUM_BITS'(stage_reg.bid) + SUM_BITS'(stage_reg.ask);
        diff     = (ref_sum > cur_sum) ? (ref_sum - cur_sum) : (cur_sum - ref_sum);
        total    = TOTAL_BITS'(ref_sum) + TOTAL_BITS'(cur_sum);
        lhs      = PROD_BITS'(diff) * PROD_BITS'(PCT_SCALE);
        rhs      = PROD_BITS'(threshold_reg) * PROD_BITS'(total);
        spiked   = (total != '0) && (lhs >= rhs);
        run_inc  = run_reg + RUN_BITS'(1);

        take_quote    = 1'b1;
        rejected_next = 1'b0;
        run_next      = '0;
        if (spiked)
        begin
            if (run_inc > RUN_BITS'(persist_reg))
            begin
                run_next = '0;
            end
            else
            begin
                run_next      = run_inc;
                take_quote    = 1'b0;
                rejected_next = 1'b1;
            end
        end

        ref_bid_next = take_quote ? stage_reg.bid : base_bid;
        ref_ask_next = take_quote ? stage_reg.ask : base_ask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg <= 1'b0;
            ref_bid_reg   <= '0;
            ref_ask_reg   <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_result)
            begin
                ref_valid_reg <= 1'b1;
                ref_bid_reg   <= ref_bid_next;
                ref_ask_reg   <= ref_ask_next;
                run_reg       <= run_next;
            end
            if (advance)
                out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            rejected_reg  <= rejected_next;
            out_quote_reg <= stage_reg;
        end
    end

    // reference and run registers track the result slot, so present them directly
    assign result_valid = out_valid_reg;
    assign rejected     = rejected_reg;
    assign fixed_bid    = out_quote_reg.bid;
    assign fixed_ask    = out_quote_reg.ask;
    assign swapped      = out_quote_reg.swapped;
    assign ref_bid      = ref_bid_reg;
    assign ref_ask      = ref_ask_reg;
    assign run_length   = run_reg;

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (run_length <= RUN_BITS'(persist_reg) + RUN_BITS'(1)))
        else $error("run length beyond persistence limit");

    a_reject_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rejected) |-> (run_length != '0))
        else $error("rejected quote with empty run");

    a_accept_sets_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !rejected) |-> (ref_bid == fixed_bid && ref_ask == fixed_ask))
        else $error("accepted quote did not become the reference");

    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (fixed_bid <= fixed_ask))
        else $error("result quote has negative spread");

    a_ref_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ref_valid_reg)
        else $error("result without a reference");

endmodule

`default_nettype wire

// ===== bench/quote_spike_filter_tb.sv =====
`timescale 1ns / 100ps

module quote_spike_filter_tb;

    import qsf_pkg::*;

    localparam longint unsigned PRICE_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic                rejected;
        price_t              fixed_bid;
        price_t              fixed_ask;
        logic                swapped;
        price_t              ref_bid;
        price_t              ref_ask;
        logic [RUN_BITS-1:0] run_length;
    } filter_result_t;

    class quote_checker;
        logic [THRESH_BITS-1:0]  thresh = THRESH_RESET;
        logic [PERSIST_BITS-1:0] persist_lim = PERSIST_RESET;
        bit                      has_ref = 0;
        price_t                  ref_b = '0;
        price_t                  ref_a = '0;
        logic [RUN_BITS-1:0]     run_cnt = '0;
        filter_result_t          filtered_q[$];
        int                      errors = 0;

        function void configure(cfg_index_t idx, logic [CFG_BITS-1:0] value);
            if (idx == REG_THRESHOLD)
                thresh = value[THRESH_BITS-1:0];
            else
                persist_lim = value[PERSIST_BITS-1:0];
        endfunction

        function bit is_spike(longint unsigned rsum, longint unsigned csum);
            longint unsigned total;
            longint unsigned diff;
            total = rsum + csum;
            diff = (rsum > csum) ? rsum - csum : csum - rsum;
            if (total == 0)
                return 0;
            return diff * 64'(PCT_SCALE) >= 64'(thresh) * total;
        endfunction

        // Predict the filter decision for one accepted quote.
        function void accept_quote(price_t bid, price_t ask);
            filter_result_t r;
            longint unsigned rsum;
            longint unsigned csum;
            bit take;
            take = 0;
            r.rejected = 0;
            r.swapped = bid > ask;
            r.fixed_bid = r.swapped ? ask : bid;
            r.fixed_ask = r.swapped ? bid : ask;
            if (!has_ref)
            begin
                has_ref = 1;
                ref_b = r.fixed_bid;
                ref_a = r.fixed_ask;
            end
            rsum = 64'(ref_b) + 64'(ref_a);
            csum = 64'(r.fixed_bid) + 64'(r.fixed_ask);
            if (is_spike(rsum, csum))
            begin
                run_cnt = run_cnt + 1'b1;
                if (run_cnt > RUN_BITS'(persist_lim))
                begin
                    run_cnt = '0;
                    take = 1;
                end
                else
                    r.rejected = 1;
            end
            else
            begin
                run_cnt = '0;
                take = 1;
            end
            if (take)
            begin
                ref_b = r.fixed_bid;
                ref_a = r.fixed_ask;
            end
            r.ref_bid = ref_b;
            r.ref_ask = ref_a;
            r.run_length = run_cnt;
            filtered_q.insert(filtered_q.size(), r);
        endfunction

        function void compare_field(string field, longint unsigned exp_v,
                                    longint unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s expected %0h got %0h", $realtime, field, exp_v, act_v);
            end
        endfunction

        function void check_filtered(filter_result_t got);
            filter_result_t want;
            if (filtered_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with no quote pending", $realtime);
                return;
            end
            want = filtered_q.pop_front();
            compare_field("rejected", want.rejected, got.rejected);
            compare_field("fixed_bid", want.fixed_bid, got.fixed_bid);
            compare_field("fixed_ask", want.fixed_ask, got.fixed_ask);
            compare_field("swapped", want.swapped, got.swapped);
            compare_field("ref_bid", want.ref_bid, got.ref_bid);
            compare_field("ref_ask", want.ref_ask, got.ref_ask);
            compare_field("run_length", want.run_length, got.run_length);
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    cfg_index_t          cfg_index = REG_THRESHOLD;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                quote_valid = 1'b0;
    logic                quote_ready;
    price_t              bid_price = '0;
    price_t              ask_price = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    logic                rejected;
    price_t              fixed_bid;
    price_t              fixed_ask;
    logic                swapped;
    price_t              ref_bid;
    price_t              ref_ask;
    logic [RUN_BITS-1:0] run_length;

    quote_checker chk = new;

    int burst_left = 1;
    int cur_persist = int'(PERSIST_RESET);
    int quotes_sent = 0;
    int stall_left = 0;
    int stall_mode = 0;
    logic [31:0] stall_mask = '1;

    logic [63:0] dir_quotes[20] = '{
        {32'd1000, 32'd1010}, {32'd1010, 32'd1000}, {32'd1000, 32'd1010},
        {32'd1010, 32'd1000},
        // sum 1990 against 2010 sits exactly on a 1% threshold, 1991 just below
        {32'd995, 32'd995}, {32'd996, 32'd995},
        {32'd0, 32'd0}, {32'd0, 32'd0}, {32'd0, 32'd0}, {32'd0, 32'd0},
        // zero total against a zero reference
        {32'd0, 32'd0},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF}, {32'hFFFF_FFFF, 32'h0}, {32'h0, 32'hFFFF_FFFF},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF}, {32'hFFFF_FFFE, 32'hFFFF_FFFF},
        {32'h8000_0000, 32'h8000_0000}, {32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'hAAAA_AAAA, 32'h5555_5555}, {32'h5555_5555, 32'hAAAA_AAAA}
    };

    int    thr_set[6]     = '{0, 20000, 50, 32767, 1, 0};
    int    persist_set[6] = '{0, 0, 255, 7, 1, 0};

    quote_spike_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .quote_valid  (quote_valid),
        .quote_ready  (quote_ready),
        .bid_price    (bid_price),
        .ask_price    (ask_price),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .rejected     (rejected),
        .fixed_bid    (fixed_bid),
        .fixed_ask    (fixed_ask),
        .swapped      (swapped),
        .ref_bid      (ref_bid),
        .ref_ask      (ref_ask),
        .run_length   (run_length)
    );

    always #2 clk = ~clk;

    // Receiver: switch among always ready, coin flip, mostly stalled and a mask pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
            stall_mask = $urandom | 32'h1;
        end
        stall_left--;
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2: result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= stall_mask[stall_left % 32];
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            chk.check_filtered(filter_result_t'{rejected, fixed_bid, fixed_ask, swapped,
                                                ref_bid, ref_ask, run_length});
    end

    task automatic write_reg(cfg_index_t idx, logic [CFG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        chk.configure(idx, value);
        if (idx == REG_PERSIST)
            cur_persist = int'(value[PERSIST_BITS-1:0]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_quote(price_t bid, price_t ask);
        quote_valid <= 1'b1;
        bid_price <= bid;
        ask_price <= ask;
        do
            @(posedge clk);
        while (!quote_ready);
        chk.accept_quote(bid, ask);
        quotes_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // end of burst: drop valid for a gap
            quote_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 20);
        end
    endtask

    task automatic send_pair(logic [63:0] q);
        send_quote(q[63:32], q[31:0]);
    endtask

    task automatic drain_quotes();
        quote_valid <= 1'b0;
        while (chk.pending() != 0) @(posedge clk);
    endtask

    function automatic longint unsigned random_level();
        case ($urandom_range(0, 3))
            0, 1: return 64'($urandom);
            2: return 64'($urandom_range(0, 1000));
            default: return 64'(32'hFFFF_FFFF - $urandom_range(0, 1000));
        endcase
    endfunction

    // Quote around a price level with jitter of a random scale; sometimes crossed.
    function automatic logic [63:0] quote_near(longint unsigned level);
        longint unsigned jit;
        longint unsigned delta;
        longint unsigned mid;
        longint unsigned b;
        longint unsigned a;
        jit = level >> $urandom_range(4, 16);
        delta = 64'($urandom_range(0, 32'(jit)));
        if ($urandom_range(0, 1) == 1)
            mid = level + delta;
        else
            mid = (delta > level) ? 0 : level - delta;
        b = mid;
        a = mid + 64'($urandom_range(0, 32'(jit >> 2) + 1));
        if (b > PRICE_MAX)
            b = PRICE_MAX;
        if (a > PRICE_MAX)
            a = PRICE_MAX;
        if ($urandom_range(0, 7) == 0)
            return {a[31:0], b[31:0]};
        return {b[31:0], a[31:0]};
    endfunction

    task automatic run_phase(int n_quotes);
        longint unsigned level;
        longint unsigned jump_level;
        int start;
        start = quotes_sent;
        // one run long enough to overrun the persistence limit
        level = random_level();
        repeat (cur_persist + 2) send_pair(quote_near(level));
        while (quotes_sent - start < n_quotes)
        begin
            case ($urandom_range(0, 19)) inside
                [0:11]:
                    repeat ($urandom_range(1, 12)) send_pair(quote_near(level));
                [12:16]:
                begin
                    jump_level = random_level();
                    repeat ($urandom_range(1, cur_persist + 2))
                        send_pair(quote_near(jump_level));
                    if ($urandom_range(0, 1) == 1)
                        level = jump_level;
                end
                default:
                    send_quote($urandom, $urandom);
            endcase
        end
        drain_quotes();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero threshold before the first quote: it spikes against itself
        write_reg(REG_THRESHOLD, '0);
        repeat (4) send_quote(32'd5, 32'd7);
        drain_quotes();
        write_reg(REG_THRESHOLD, CFG_BITS'(THRESH_RESET));
        for (int i = 0; i < 20; i++)
            send_pair(dir_quotes[i]);
        drain_quotes();

        thr_set[5] = $urandom_range(0, 32767);
        persist_set[5] = $urandom_range(0, 15);
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_THRESHOLD, CFG_BITS'(thr_set[p]));
            write_reg(REG_PERSIST, CFG_BITS'(persist_set[p]));
            run_phase(265);
        end

        repeat (10) @(posedge clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("quote_spike_filter_tb: done, clean");
        else
            $display("quote_spike_filter_tb: done, errors");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("quote_spike_filter_tb: done, errors");
        $finish;
    end

endmodule
